// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file irc_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define IRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define IRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/irc_pkg.sv =====
// types, constants and register map of the ir command / servo controller
// no dependencies
`default_nettype none

package irc_pkg;

  localparam int unsigned TICK_W = 32;
  localparam int unsigned WIN_W  = 10;
  localparam int unsigned THR_W  = 8;
  localparam int unsigned DUTY_W = 7;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  localparam int unsigned PWM_PERIOD_DEF = 100;
  localparam int unsigned WAG_PERIOD_DEF = 1500;

  typedef enum logic [2:0] {
    REG_LEADER    = 3'd0,
    REG_SKIP      = 3'd1,
    REG_READ      = 3'd2,
    REG_THRESH    = 3'd3,
    REG_IDLE_DUTY = 3'd4,
    REG_WAG_LOW   = 3'd5,
    REG_WAG_HIGH  = 3'd6
  } reg_idx_t;

  localparam logic [CODE_W-1:0] CODE_WAG   = 8'd96;
  localparam logic [CODE_W-1:0] CODE_UP    = 8'd93;
  localparam logic [CODE_W-1:0] CODE_DOWN  = 8'd157;
  localparam logic [CODE_W-1:0] CODE_LEFT  = 8'd29;
  localparam logic [CODE_W-1:0] CODE_RIGHT = 8'd237;

  localparam logic [WIN_W-1:0]  RST_LEADER    = 10'd45;
  localparam logic [WIN_W-1:0]  RST_SKIP      = 10'd157;
  localparam logic [WIN_W-1:0]  RST_READ      = 10'd157;
  localparam logic [THR_W-1:0]  RST_THRESH    = 8'd4;
  localparam logic [DUTY_W-1:0] RST_IDLE_DUTY = 7'd8;
  localparam logic [DUTY_W-1:0] RST_WAG_LOW   = 7'd5;
  localparam logic [DUTY_W-1:0] RST_WAG_HIGH  = 7'd12;
  localparam logic [DUTY_W-1:0] RST_DUTY      = 7'd5;

  typedef struct packed {
    logic [WIN_W-1:0]  leader_ticks;
    logic [WIN_W-1:0]  skip_ticks;
    logic [WIN_W-1:0]  read_ticks;
    logic [THR_W-1:0]  one_threshold_ticks;
    logic [DUTY_W-1:0] idle_duty;
    logic [DUTY_W-1:0] wag_low_duty;
    logic [DUTY_W-1:0] wag_high_duty;
  } cfg_t;

  typedef struct packed {
    logic              tail_pwm;
    logic              red_led;
    logic              green_led;
    logic              motor_a;
    logic              motor_b;
    logic [CODE_W-1:0] command_code;
    logic              wag_on;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/ir_command_motor_servo_controller.sv =====
// top level: input register, decoder core, result register, config port
// depends on irc_pkg, irc_cfg, irc_core
`default_nettype none

// Takes one IR sample per item and returns one result item per sample:
// servo pwm level, indicator and motor lines, the current 8-bit command
// and the wag flag. One item is accepted every cycle unless out_ready
// stalls the output; the input register is loaded at the accepting
// edge and the state update loads the result register once it is free,
// and the state update itself sets the one-item-per-cycle rate.
// PWM_PERIOD and WAG_PERIOD set the servo period and the wag alternation
// interval in items. Registers are to be written over the APB port at
// 4*index only while idle; the block itself does not enforce this.
module ir_command_motor_servo_controller #(
  parameter int unsigned PWM_PERIOD = irc_pkg::PWM_PERIOD_DEF,
  parameter int unsigned WAG_PERIOD = irc_pkg::WAG_PERIOD_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_ir_active,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_tail_pwm,
  output logic                            out_red_led,
  output logic                            out_green_led,
  output logic                            out_motor_a,
  output logic                            out_motor_b,
  output logic      [irc_pkg::CODE_W-1:0] out_command_code,
  output logic                            out_wag_on,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [irc_pkg::APB_AW-1:0] paddr,
  input  wire logic [irc_pkg::APB_DW-1:0] pwdata,
  output logic      [irc_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import irc_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t res_r;
  logic    s1_valid_r, s1_valid_nxt;
  logic    s1_act_r;
  logic    out_valid_r, out_valid_nxt;
  logic    adv;
  logic    in_acc;

  irc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  irc_core #(
    .PWM_PERIOD (PWM_PERIOD),
    .WAG_PERIOD (WAG_PERIOD)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .ir_active (s1_act_r),
    .cfg       (cfg),
    .res       (res)
  );

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_act_r <= in_ir_active;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tail_pwm     = res_r.tail_pwm;
  assign out_red_led      = res_r.red_led;
  assign out_green_led    = res_r.green_led;
  assign out_motor_a      = res_r.motor_a;
  assign out_motor_b      = res_r.motor_b;
  assign out_command_code = res_r.command_code;
  assign out_wag_on       = res_r.wag_on;

endmodule

`default_nettype wire

// ===== rtl/core/irc_cfg.sv =====
// apb-style configuration registers of the ir command / servo controller
// depends on irc_pkg
`default_nettype none

module irc_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [irc_pkg::APB_AW-1:0] paddr,
  input  wire logic [irc_pkg::APB_DW-1:0] pwdata,
  output logic      [irc_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output irc_pkg::cfg_t                   cfg
);
  import irc_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_LEADER:    cfg_nxt.leader_ticks        = pwdata[WIN_W-1:0];
        REG_SKIP:      cfg_nxt.skip_ticks          = pwdata[WIN_W-1:0];
        REG_READ:      cfg_nxt.read_ticks          = pwdata[WIN_W-1:0];
        REG_THRESH:    cfg_nxt.one_threshold_ticks = pwdata[THR_W-1:0];
        REG_IDLE_DUTY: cfg_nxt.idle_duty           = pwdata[DUTY_W-1:0];
        REG_WAG_LOW:   cfg_nxt.wag_low_duty        = pwdata[DUTY_W-1:0];
        REG_WAG_HIGH:  cfg_nxt.wag_high_duty       = pwdata[DUTY_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LEADER:    prdata = APB_DW'(cfg_r.leader_ticks);
      REG_SKIP:      prdata = APB_DW'(cfg_r.skip_ticks);
      REG_READ:      prdata = APB_DW'(cfg_r.read_ticks);
      REG_THRESH:    prdata = APB_DW'(cfg_r.one_threshold_ticks);
      REG_IDLE_DUTY: prdata = APB_DW'(cfg_r.idle_duty);
      REG_WAG_LOW:   prdata = APB_DW'(cfg_r.wag_low_duty);
      REG_WAG_HIGH:  prdata = APB_DW'(cfg_r.wag_high_duty);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.leader_ticks        <= RST_LEADER;
      cfg_r.skip_ticks          <= RST_SKIP;
      cfg_r.read_ticks          <= RST_READ;
      cfg_r.one_threshold_ticks <= RST_THRESH;
      cfg_r.idle_duty           <= RST_IDLE_DUTY;
      cfg_r.wag_low_duty        <= RST_WAG_LOW;
      cfg_r.wag_high_duty       <= RST_WAG_HIGH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/irc_core.sv =====
// per-tick frame decoder, command map and servo pwm state
// depends on irc_pkg
`default_nettype none

module irc_core #(
  parameter int unsigned PWM_PERIOD = irc_pkg::PWM_PERIOD_DEF,
  parameter int unsigned WAG_PERIOD = irc_pkg::WAG_PERIOD_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire logic         ir_active,
  input  wire irc_pkg::cfg_t cfg,
  output irc_pkg::result_t  res
);
  import irc_pkg::*;

  localparam int unsigned PH_W  = $clog2(PWM_PERIOD);
  localparam int unsigned WG_W  = $clog2(WAG_PERIOD);
  localparam int unsigned CMP_W = (PH_W > DUTY_W) ? PH_W : DUTY_W;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(PWM_PERIOD - 1);
  localparam logic [WG_W-1:0] WG_LAST = WG_W'(WAG_PERIOD - 1);

  logic [TICK_W-1:0] tick_r,      tick_nxt;
  logic [TICK_W-1:0] leader_dl_r, leader_dl_nxt;
  logic [TICK_W-1:0] skip_dl_r,   skip_dl_nxt;
  logic [TICK_W-1:0] read_dl_r,   read_dl_nxt;
  logic [TICK_W-1:0] gap_dl_r,    gap_dl_nxt;
  logic [CODE_W-1:0] shift_r,     shift_nxt;
  logic              wag_r,       wag_nxt;
  logic [DUTY_W-1:0] duty_r,      duty_nxt;
  logic [PH_W-1:0]   phase_prev_r, phase_prev_nxt;
  logic [PH_W-1:0]   phase_r,     phase_nxt;
  logic [WG_W-1:0]   wag_cnt_r,   wag_cnt_nxt;
  logic              wag_par_r,   wag_par_nxt;
  logic              tick_last;

  always_comb begin
    tick_last     = &tick_r;
    leader_dl_nxt = leader_dl_r;
    skip_dl_nxt   = skip_dl_r;
    read_dl_nxt   = read_dl_r;
    gap_dl_nxt    = gap_dl_r;
    shift_nxt     = shift_r;
    wag_nxt       = wag_r;
    duty_nxt      = duty_r;
    res           = '0;

    // frame tracking
    if (!ir_active && (read_dl_r == '0) && (skip_dl_r == '0)) begin
      leader_dl_nxt = tick_r + TICK_W'(cfg.leader_ticks);
    end else if ((tick_r > leader_dl_r) && ir_active && (skip_dl_r == '0)) begin
      skip_dl_nxt = tick_r + TICK_W'(cfg.skip_ticks);
    end else if (skip_dl_r > tick_r) begin
      read_dl_nxt = tick_r + TICK_W'(cfg.read_ticks);
    end else if (read_dl_r > tick_r) begin
      if (ir_active) begin
        if (gap_dl_r != '0) begin
          shift_nxt  = {shift_r[CODE_W-2:0], tick_r > gap_dl_r};
          gap_dl_nxt = '0;
        end
      end else if (gap_dl_r == '0) begin
        gap_dl_nxt = tick_r + TICK_W'(cfg.one_threshold_ticks);
      end
    end else begin
      read_dl_nxt = '0;
      skip_dl_nxt = '0;
    end

    // command map
    case (shift_nxt)
      CODE_WAG:   wag_nxt = 1'b1;
      CODE_UP:    begin res.red_led   = 1'b1; res.motor_a = 1'b1; end
      CODE_DOWN:  begin res.green_led = 1'b1; res.motor_b = 1'b1; end
      CODE_LEFT:  begin res.green_led = 1'b1; res.motor_a = 1'b1; end
      CODE_RIGHT: begin res.red_led   = 1'b1; res.motor_b = 1'b1; end
      default:    wag_nxt = 1'b0;
    endcase

    // servo duty
    if (wag_nxt) begin
      if (wag_cnt_r == '0) begin
        duty_nxt = wag_par_r ? cfg.wag_low_duty : cfg.wag_high_duty;
      end
    end else begin
      duty_nxt = cfg.idle_duty;
    end

    res.tail_pwm     = CMP_W'(phase_prev_r) <= CMP_W'(duty_nxt);
    res.command_code = shift_nxt;
    res.wag_on       = wag_nxt;

    // tick and its residues
    phase_prev_nxt = phase_r;
    tick_nxt       = tick_r + TICK_W'(1);
    phase_nxt      = (tick_last || (phase_r == PH_LAST)) ? '0 : phase_r + PH_W'(1);
    wag_cnt_nxt    = (tick_last || (wag_cnt_r == WG_LAST)) ? '0 : wag_cnt_r + WG_W'(1);
    wag_par_nxt    = tick_last ? 1'b0 : ((wag_cnt_r == WG_LAST) ? !wag_par_r : wag_par_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r       <= '0;
      leader_dl_r  <= '0;
      skip_dl_r    <= '0;
      read_dl_r    <= '0;
      gap_dl_r     <= '0;
      shift_r      <= '0;
      wag_r        <= 1'b0;
      duty_r       <= RST_DUTY;
      phase_prev_r <= '0;
      phase_r      <= '0;
      wag_cnt_r    <= '0;
      wag_par_r    <= 1'b0;
    end else if (step) begin
      tick_r       <= tick_nxt;
      leader_dl_r  <= leader_dl_nxt;
      skip_dl_r    <= skip_dl_nxt;
      read_dl_r    <= read_dl_nxt;
      gap_dl_r     <= gap_dl_nxt;
      shift_r      <= shift_nxt;
      wag_r        <= wag_nxt;
      duty_r       <= duty_nxt;
      phase_prev_r <= phase_prev_nxt;
      phase_r      <= phase_nxt;
      wag_cnt_r    <= wag_cnt_nxt;
      wag_par_r    <= wag_par_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/irc_checker.sv =====
// port-level checks of the ir command / servo controller, bound to the top
// depends on irc_pkg, assert_macros.svh, ir_command_motor_servo_controller
`default_nettype none
`include "assert_macros.svh"

module irc_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic                       out_red_led,
  input wire logic                       out_green_led,
  input wire logic                       out_motor_a,
  input wire logic                       out_motor_b,
  input wire logic [irc_pkg::CODE_W-1:0] out_command_code,
  input wire logic                       out_wag_on
);
  import irc_pkg::*;

  `IRC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_command_code), "stalled result item changed")
  `IRC_ASSERT_IMP(a_lines_excl, clk, rst_n, out_valid, !(out_red_led && out_green_led) && !(out_motor_a && out_motor_b), "conflicting drive lines")
  `IRC_ASSERT_IMP(a_wag_quiet, clk, rst_n, out_valid && out_wag_on, !(out_red_led || out_green_led || out_motor_a || out_motor_b), "drive line active while wagging")
  `IRC_ASSERT_IMP(a_wag_code, clk, rst_n, out_valid && (out_command_code == CODE_WAG), out_wag_on, "wag code without wag mode")

endmodule

bind ir_command_motor_servo_controller irc_checker u_irc_checker (.*);

`default_nettype wire
